[hw/rtl/mhpq_pkg.sv]
package mhpq_pkg;

   localparam int MHPQ_CAPACITY = 127;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef logic [1:0] status_type;
   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

   typedef struct packed {
      logic accept;
      logic start_ins;
      logic start_rem;
      logic load_last;
      logic rd_parent;
      logic rd_children;
      logic move_up;
      logic move_down;
      logic place;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic op_remove;
      logic full;
      logic empty;
      logic at_root;
      logic leaf;
      logic parent_less;
      logic child_wins;
   } stat_type;

endpackage

[hw/rtl/mhpq_if.sv]
interface mhpq_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

interface mhpq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] top_value;
   logic [6:0]         count;
   logic               empty_res;

   modport source (output valid, output status, output top_value, output count,
                   output empty_res, input ready);
   modport sink (input valid, input status, input top_value, input count,
                 input empty_res, output ready);
endinterface

[hw/rtl/mhpq_ctrl.sv]
module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_UP_RD  = 3'd2;
   localparam logic [2:0] S_UP_CMP = 3'd3;
   localparam logic [2:0] S_DN_RD  = 3'd4;
   localparam logic [2:0] S_DN_CMP = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.op_remove) begin
                  if (stat.empty) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.start_rem = 1'b1;
                     state_in      = S_LOAD;
                  end
               end else begin
                  if (stat.full) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.start_ins = 1'b1;
                     state_in      = S_UP_RD;
                  end
               end
            end
         end
         S_LOAD: begin
            cmd.load_last = 1'b1;
            state_in      = S_DN_RD;
         end
         S_UP_RD: begin
            if (stat.at_root) begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end else begin
               cmd.rd_parent = 1'b1;
               state_in      = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.parent_less) begin
               cmd.move_up = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_DN_RD: begin
            if (stat.leaf) begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end else begin
               cmd.rd_children = 1'b1;
               state_in        = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (stat.child_wins) begin
               cmd.move_down = 1'b1;
               state_in      = S_DN_RD;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/mhpq_dpath.sv]
module mhpq_dpath
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = MHPQ_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_opcode,
   input  logic signed [31:0] req_value,
   input  cmd_type            cmd,
   output stat_type           stat,
   output status_type         rsp_status,
   output logic signed [31:0] rsp_top_value,
   output logic [6:0]         rsp_count,
   output logic               rsp_empty_res
);

   localparam int AW = $clog2(CAPACITY + 1);

   logic [31:0]        heap_mem [0:(1 << AW) - 1];

   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] root_ff;
   logic signed [31:0] rd_a_ff, rd_b_ff;
   status_type         status_ff;
   status_type         rsp_status_ff;
   logic signed [31:0] rsp_top_ff;
   logic [6:0]         rsp_count_ff;
   logic               rsp_empty_ff;

   logic [AW:0]        left, right;
   logic               right_ok;
   logic               take_right;
   logic signed [31:0] best_val;
   logic [AW-1:0]      best_pos;
   logic [AW-1:0]      addr_a, addr_b;
   logic               wr_en;
   logic signed [31:0] wr_data;
   logic [AW+6:0]      cnt_ext;
   logic               full, empty;

   assign full  = (cnt_ff == AW'(CAPACITY));
   assign empty = (cnt_ff == '0);

   assign left       = {pos_ff, 1'b0};
   assign right      = {pos_ff, 1'b1};
   assign right_ok   = (right <= {1'b0, cnt_ff});
   assign take_right = right_ok && (rd_b_ff > rd_a_ff);
   assign best_val   = take_right ? rd_b_ff : rd_a_ff;
   assign best_pos   = take_right ? right[AW-1:0] : left[AW-1:0];

   assign stat.op_remove   = (req_opcode == OP_REMOVE);
   assign stat.full        = full;
   assign stat.empty       = empty;
   assign stat.at_root     = (pos_ff == AW'(1));
   assign stat.leaf        = (left > {1'b0, cnt_ff});
   assign stat.parent_less = (val_ff > rd_a_ff);
   assign stat.child_wins  = (best_val > val_ff);

   always_comb begin
      priority if (cmd.rd_parent) begin
         addr_a = pos_ff >> 1;
      end else if (cmd.rd_children) begin
         addr_a = left[AW-1:0];
      end else begin
         addr_a = cnt_ff;
      end
   end
   assign addr_b = right[AW-1:0];

   assign wr_en = cmd.move_up || cmd.move_down || cmd.place;

   always_comb begin
      priority if (cmd.move_up) begin
         wr_data = rd_a_ff;
      end else if (cmd.move_down) begin
         wr_data = best_val;
      end else begin
         wr_data = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[pos_ff] <= wr_data;
      end
      rd_a_ff <= heap_mem[addr_a];
      rd_b_ff <= heap_mem[addr_b];
   end

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      val_in = val_ff;
      priority if (cmd.start_ins) begin
         cnt_in = cnt_ff + AW'(1);
         pos_in = cnt_ff + AW'(1);
         val_in = req_value;
      end else if (cmd.start_rem) begin
         cnt_in = cnt_ff - AW'(1);
         pos_in = AW'(1);
      end else if (cmd.load_last) begin
         val_in = rd_a_ff;
      end else if (cmd.move_up) begin
         pos_in = pos_ff >> 1;
      end else if (cmd.move_down) begin
         pos_in = best_pos;
      end
   end

   assign cnt_ext = {7'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      val_ff <= val_in;
      if (wr_en && (pos_ff == AW'(1))) begin
         root_ff <= wr_data;
      end
      if (cmd.accept) begin
         if (req_opcode == OP_REMOVE) begin
            status_ff <= empty ? ST_EMPTY : ST_DONE;
         end else begin
            status_ff <= full ? ST_FULL : ST_DONE;
         end
      end
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_top_ff    <= empty ? 32'sd0 : root_ff;
         rsp_count_ff  <= cnt_ext[6:0];
         rsp_empty_ff  <= empty;
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule

[hw/rtl/max_heap_priority_queue_unit.sv]
// Channel  Dir  Beat fields                               Handshake
// req_ch   in   opcode, value                             valid / ready
// rsp_ch   out  status, top_value, count, empty_res       valid / ready
//
// An insert starts the new key in a new last slot and climbs it one level per
// parent read and compare until it meets the root or a parent that is not smaller;
// a remove loads the last key, starts it at the root and sinks it one level per
// children read and compare on the heap memory until it meets a leaf or has no
// larger child. Rejected operations skip the heap and go straight to the result.
// Reset is synchronous and empties the heap; the memory needs no clearing.
// A result beat waits in an output register, and a stalled result holds only
// the next result, not the next request.
module max_heap_priority_queue_unit
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = MHPQ_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   mhpq_req_if.sink   req_ch,
   mhpq_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mhpq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_opcode    (req_ch.opcode),
      .req_value     (req_ch.value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_ch.status),
      .rsp_top_value (rsp_ch.top_value),
      .rsp_count     (rsp_ch.count),
      .rsp_empty_res (rsp_ch.empty_res)
   );

endmodule

[hw/rtl/mhpq_checker.sv]
module mhpq_checker
   import mhpq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_top_value,
   input logic [6:0]         rsp_count,
   input logic               rsp_empty_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_top_value) && $stable(rsp_count) && $stable(rsp_empty_res))
      else $error("result beat changed while stalled");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_count == 7'd0 && rsp_top_value == 32'sd0)
      else $error("empty result with nonzero count or top value");

   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_empty_res)
      else $error("remove rejected on a heap that is not empty");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result beat in the cycle after its request");

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_top_value (rsp_ch.top_value),
   .rsp_count     (rsp_ch.count),
   .rsp_empty_res (rsp_ch.empty_res)
);
